// File: hw/rtl/pit_pkg.sv
package pit_pkg;

    localparam int VERT_WIDTH      = 48;
    localparam int SLOT_WIDTH      = 16;
    localparam int VOL_WIDTH       = 51;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int IN_TDATA_WIDTH  = 48;
    localparam int OUT_TDATA_WIDTH = 56;

    localparam int FACES    = 4;
    localparam int AXES     = 3;
    localparam int DET_FACE = 3;

    localparam int SETTLE_CYCLES = 6;
    localparam int SETTLE_WIDTH  = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_A = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_B = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_C = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_D = 8'd3;

    // face f uses vertices f, f+1, f+2 and tests against vertex f+3 (mod 4)
    localparam int FACE_P2  [FACES] = '{1, 2, 3, 0};
    localparam int FACE_P3  [FACES] = '{2, 3, 0, 1};
    localparam int FACE_REF [FACES] = '{3, 0, 1, 2};
    localparam int AXIS_K1  [AXES]  = '{1, 2, 0};
    localparam int AXIS_K2  [AXES]  = '{2, 0, 1};

    typedef struct packed {
        logic zero;
        logic neg;
    } pit_sign_t;

    function automatic logic sign_match(pit_sign_t a, pit_sign_t b);
        return (a.zero == b.zero) && (a.zero || (a.neg == b.neg));
    endfunction

endpackage

// File: hw/rtl/pit_geom.sv
module pit_geom #(
    parameter int COORD_WIDTH
) (
    input  logic                                  aclk,
    input  logic [pit_pkg::VERT_WIDTH-1:0]        vertex_a,
    input  logic [pit_pkg::VERT_WIDTH-1:0]        vertex_b,
    input  logic [pit_pkg::VERT_WIDTH-1:0]        vertex_c,
    input  logic [pit_pkg::VERT_WIDTH-1:0]        vertex_d,
    output logic signed [COORD_WIDTH-1:0]         base    [pit_pkg::FACES][pit_pkg::AXES],
    output logic signed [2*COORD_WIDTH+2:0]       nrm     [pit_pkg::FACES][pit_pkg::AXES],
    output pit_pkg::pit_sign_t                    ref_sgn [pit_pkg::FACES],
    output logic [pit_pkg::VOL_WIDTH-1:0]         vol
);

    localparam int CW  = COORD_WIDTH;
    localparam int DFW = CW + 1;
    localparam int PW  = 2 * CW + 2;
    localparam int NW  = 2 * CW + 3;
    localparam int TW  = 3 * CW + 4;
    localparam int DW  = 3 * CW + 6;
    localparam int MW  = (DW > pit_pkg::VOL_WIDTH) ? DW : pit_pkg::VOL_WIDTH;

    logic [pit_pkg::VERT_WIDTH-1:0] vert [pit_pkg::FACES];

    logic signed [DFW-1:0] e1_reg  [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [DFW-1:0] e2_reg  [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [DFW-1:0] rd1_reg [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [PW-1:0]  pa_reg  [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [PW-1:0]  pb_reg  [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [DFW-1:0] rd2_reg [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [NW-1:0]  nrm_reg [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [DFW-1:0] rd3_reg [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [TW-1:0]  dp_reg  [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [DW-1:0]  dot_reg [pit_pkg::FACES];
    pit_pkg::pit_sign_t    sgn_reg [pit_pkg::FACES];
    logic [pit_pkg::VOL_WIDTH-1:0] vol_reg;

    logic [DW-1:0] mag;
    logic [MW-1:0] mag_ext;

    assign vert[0] = vertex_a;
    assign vert[1] = vertex_b;
    assign vert[2] = vertex_c;
    assign vert[3] = vertex_d;

    always_comb begin
        logic [pit_pkg::SLOT_WIDTH-1:0] slot;
        slot = '0;
        for (int f = 0; f < pit_pkg::FACES; f++) begin
            for (int k = 0; k < pit_pkg::AXES; k++) begin
                slot = vert[f][pit_pkg::SLOT_WIDTH*(pit_pkg::AXES-1-k) +: pit_pkg::SLOT_WIDTH];
                base[f][k] = slot[CW-1:0];
            end
        end
    end

    // edges, products, normals, reference dots, signs
    always_ff @(posedge aclk) begin
        for (int f = 0; f < pit_pkg::FACES; f++) begin
            for (int k = 0; k < pit_pkg::AXES; k++) begin
                e1_reg[f][k]  <= DFW'(base[pit_pkg::FACE_P2[f]][k]) - DFW'(base[f][k]);
                e2_reg[f][k]  <= DFW'(base[pit_pkg::FACE_P3[f]][k]) - DFW'(base[f][k]);
                rd1_reg[f][k] <= DFW'(base[pit_pkg::FACE_REF[f]][k]) - DFW'(base[f][k]);
                pa_reg[f][k]  <= PW'(e1_reg[f][pit_pkg::AXIS_K1[k]])
                               * PW'(e2_reg[f][pit_pkg::AXIS_K2[k]]);
                pb_reg[f][k]  <= PW'(e1_reg[f][pit_pkg::AXIS_K2[k]])
                               * PW'(e2_reg[f][pit_pkg::AXIS_K1[k]]);
                rd2_reg[f][k] <= rd1_reg[f][k];
                nrm_reg[f][k] <= NW'(pa_reg[f][k]) - NW'(pb_reg[f][k]);
                rd3_reg[f][k] <= rd2_reg[f][k];
                dp_reg[f][k]  <= TW'(nrm_reg[f][k]) * TW'(rd3_reg[f][k]);
            end
            dot_reg[f]      <= DW'(dp_reg[f][0]) + DW'(dp_reg[f][1]) + DW'(dp_reg[f][2]);
            sgn_reg[f].zero <= (dot_reg[f] == '0);
            sgn_reg[f].neg  <= dot_reg[f][DW-1];
        end
        vol_reg <= mag_ext[pit_pkg::VOL_WIDTH-1:0];
    end

    // the last face's reference dot is the determinant of A-D, B-D, C-D
    always_comb begin
        mag     = dot_reg[pit_pkg::DET_FACE][DW-1] ? DW'(-dot_reg[pit_pkg::DET_FACE])
                                                   : DW'(dot_reg[pit_pkg::DET_FACE]);
        mag_ext = MW'(mag);
    end

    assign nrm     = nrm_reg;
    assign ref_sgn = sgn_reg;
    assign vol     = vol_reg;

endmodule

// File: hw/rtl/pit_query.sv
module pit_query #(
    parameter int COORD_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [pit_pkg::SLOT_WIDTH-1:0]        query_x,
    input  logic [pit_pkg::SLOT_WIDTH-1:0]        query_y,
    input  logic [pit_pkg::SLOT_WIDTH-1:0]        query_z,
    input  logic signed [COORD_WIDTH-1:0]         base    [pit_pkg::FACES][pit_pkg::AXES],
    input  logic signed [2*COORD_WIDTH+2:0]       nrm     [pit_pkg::FACES][pit_pkg::AXES],
    input  pit_pkg::pit_sign_t                    ref_sgn [pit_pkg::FACES],
    input  logic [pit_pkg::VOL_WIDTH-1:0]         vol,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  inside_res,
    output logic [pit_pkg::VOL_WIDTH-1:0]         six_volume
);

    localparam int CW  = COORD_WIDTH;
    localparam int DFW = CW + 1;
    localparam int TW  = 3 * CW + 4;
    localparam int DW  = 3 * CW + 6;

    logic signed [CW-1:0]  q [pit_pkg::AXES];

    logic                  va_reg;
    logic                  vb_reg;
    logic                  vc_reg;
    logic                  vd_reg;
    logic                  rd_a;
    logic                  rd_b;
    logic                  rd_c;
    logic                  rd_d;

    logic signed [DFW-1:0] dq_reg [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [TW-1:0]  qp_reg [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [DW-1:0]  qd_reg [pit_pkg::FACES];
    logic                  inside_reg;
    logic [pit_pkg::VOL_WIDTH-1:0] vol_reg;
    logic                  inside_next;

    assign q[0] = query_x[CW-1:0];
    assign q[1] = query_y[CW-1:0];
    assign q[2] = query_z[CW-1:0];

    assign rd_d     = !vd_reg || out_ready;
    assign rd_c     = !vc_reg || rd_d;
    assign rd_b     = !vb_reg || rd_c;
    assign rd_a     = !va_reg || rd_b;
    assign in_ready = rd_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (rd_a) begin
                va_reg <= in_valid;
            end
            if (rd_b) begin
                vb_reg <= va_reg;
            end
            if (rd_c) begin
                vc_reg <= vb_reg;
            end
            if (rd_d) begin
                vd_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int f = 0; f < pit_pkg::FACES; f++) begin
            for (int k = 0; k < pit_pkg::AXES; k++) begin
                if (rd_a && in_valid) begin
                    dq_reg[f][k] <= DFW'(q[k]) - DFW'(base[f][k]);
                end
                if (rd_b && va_reg) begin
                    qp_reg[f][k] <= TW'(nrm[f][k]) * TW'(dq_reg[f][k]);
                end
            end
            if (rd_c && vb_reg) begin
                qd_reg[f] <= DW'(qp_reg[f][0]) + DW'(qp_reg[f][1]) + DW'(qp_reg[f][2]);
            end
        end
        if (rd_d && vc_reg) begin
            inside_reg <= inside_next;
            vol_reg    <= vol;
        end
    end

    always_comb begin
        pit_pkg::pit_sign_t s;
        s           = '0;
        inside_next = 1'b1;
        for (int f = 0; f < pit_pkg::FACES; f++) begin
            s.zero      = (qd_reg[f] == '0);
            s.neg       = qd_reg[f][DW-1];
            inside_next = inside_next && pit_pkg::sign_match(ref_sgn[f], s);
        end
    end

    assign out_valid  = vd_reg;
    assign inside_res = inside_reg;
    assign six_volume = vol_reg;

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> va_reg)
        else $error("accepted request did not reach first stage");

    a_first_held: assert property (@(posedge aclk) disable iff (!aresetn)
        va_reg && !rd_b |=> va_reg)
        else $error("blocked request dropped from first stage");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (va_reg && vb_reg && vc_reg && vd_reg))
        else $error("input held off with a bubble in the pipeline");

endmodule

// File: hw/rtl/point_in_tetrahedron_test_core.sv
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_tvalid/s_tready  | s_tdata: query_x, query_y, query_z
// m_      | out       | m_tvalid/m_tready  | m_tdata: inside_res, six_volume
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (vertex_a..vertex_d)
//
// One query per cycle while the m_ side drains results and the face data has settled;
// each result passes the query pipeline in order (difference, product, sum, sign compare).
// aresetn is synchronous: after reset and after each configuration write the face
// pipeline must settle, and s_tready stays low until the settle count runs out.
// A stalled m_ side holds the result; the stages behind it fill any bubbles first.
module point_in_tetrahedron_test_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [pit_pkg::IN_TDATA_WIDTH-1:0]     s_tdata,   // query_x, query_y, query_z
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [pit_pkg::OUT_TDATA_WIDTH-1:0]    m_tdata,   // inside_res, six_volume, zero pad
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pit_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pit_pkg::VERT_WIDTH-1:0]         cfg_data
);

    logic [pit_pkg::VERT_WIDTH-1:0]   vertex_a_reg;
    logic [pit_pkg::VERT_WIDTH-1:0]   vertex_b_reg;
    logic [pit_pkg::VERT_WIDTH-1:0]   vertex_c_reg;
    logic [pit_pkg::VERT_WIDTH-1:0]   vertex_d_reg;
    logic [pit_pkg::SETTLE_WIDTH-1:0] settle_cnt_reg;
    logic [pit_pkg::SETTLE_WIDTH-1:0] settle_cnt_next;
    logic                             cfg_write;
    logic                             settled;

    logic signed [COORD_WIDTH-1:0]    base    [pit_pkg::FACES][pit_pkg::AXES];
    logic signed [2*COORD_WIDTH+2:0]  nrm     [pit_pkg::FACES][pit_pkg::AXES];
    pit_pkg::pit_sign_t               ref_sgn [pit_pkg::FACES];
    logic [pit_pkg::VOL_WIDTH-1:0]    vol;

    logic                             q_ready;
    logic                             inside_res;
    logic [pit_pkg::VOL_WIDTH-1:0]    six_volume;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign settled   = (settle_cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_a_reg <= '0;
            vertex_b_reg <= '0;
            vertex_c_reg <= '0;
            vertex_d_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                pit_pkg::REG_VERTEX_A: vertex_a_reg <= cfg_data;
                pit_pkg::REG_VERTEX_B: vertex_b_reg <= cfg_data;
                pit_pkg::REG_VERTEX_C: vertex_c_reg <= cfg_data;
                pit_pkg::REG_VERTEX_D: vertex_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (cfg_write) begin
            settle_cnt_next = pit_pkg::SETTLE_WIDTH'(pit_pkg::SETTLE_CYCLES);
        end else if (!settled) begin
            settle_cnt_next = settle_cnt_reg - 1'b1;
        end else begin
            settle_cnt_next = settle_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_cnt_reg <= pit_pkg::SETTLE_WIDTH'(pit_pkg::SETTLE_CYCLES);
        end else begin
            settle_cnt_reg <= settle_cnt_next;
        end
    end

    pit_geom #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_geom (
        .aclk    (aclk),
        .vertex_a(vertex_a_reg),
        .vertex_b(vertex_b_reg),
        .vertex_c(vertex_c_reg),
        .vertex_d(vertex_d_reg),
        .base    (base),
        .nrm     (nrm),
        .ref_sgn (ref_sgn),
        .vol     (vol)
    );

    pit_query #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_query (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && settled),
        .in_ready  (q_ready),
        .query_x   (s_tdata[15:0]),
        .query_y   (s_tdata[31:16]),
        .query_z   (s_tdata[47:32]),
        .base      (base),
        .nrm       (nrm),
        .ref_sgn   (ref_sgn),
        .vol       (vol),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .inside_res(inside_res),
        .six_volume(six_volume)
    );

    assign s_tready = q_ready && settled;
    assign m_tdata  = {4'b0000, six_volume, inside_res};

    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_write |=> !s_tready)
        else $error("request taken while face data settles");

    a_reset_settle: assert property (@(posedge aclk)
        !aresetn |=> (settle_cnt_reg == pit_pkg::SETTLE_WIDTH'(pit_pkg::SETTLE_CYCLES))
                     && !m_tvalid)
        else $error("settle count or output not restored by reset");

endmodule

// File: tb/tb_point_in_tetrahedron_test_core.sv
`timescale 1ns / 1ps

module tb_point_in_tetrahedron_test_core;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec3_t;

    typedef struct {
        bit                          in_tet;
        bit [pit_pkg::VOL_WIDTH-1:0] six_vol;
    } verdict_t;

    typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_BLOCKY} rx_mode_t;
    typedef enum logic [1:0] {SHAPE_WIDE, SHAPE_COMPACT, SHAPE_FLAT, SHAPE_CORNERS} shape_t;

    class tet_verdicts;
        bit [pit_pkg::VERT_WIDTH-1:0] vertex [pit_pkg::FACES];
        verdict_t                     pending [$];
        int unsigned                  faults;

        function new();
            foreach (vertex[i]) vertex[i] = '0;
            faults = 0;
        endfunction

        function void flag(string msg);
            faults++;
            if (faults <= 10) $display("[%0t] %s", $realtime, msg);
        endfunction

        function void set_vertex(logic [pit_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                 logic [pit_pkg::VERT_WIDTH-1:0] data);
            if (idx <= pit_pkg::REG_VERTEX_D) vertex[idx[1:0]] = data;
        endfunction

        static function longint slot_value(logic [pit_pkg::SLOT_WIDTH-1:0] slot);
            return longint'($signed(slot));
        endfunction

        static function vec3_t unpack_vertex(bit [pit_pkg::VERT_WIDTH-1:0] r);
            vec3_t p;
            p.x = slot_value(r[47:32]);
            p.y = slot_value(r[31:16]);
            p.z = slot_value(r[15:0]);
            return p;
        endfunction

        static function vec3_t diff(vec3_t a, vec3_t b);
            vec3_t r;
            r.x = a.x - b.x;
            r.y = a.y - b.y;
            r.z = a.z - b.z;
            return r;
        endfunction

        static function vec3_t cross3(vec3_t a, vec3_t b);
            vec3_t r;
            r.x = a.y * b.z - a.z * b.y;
            r.y = a.z * b.x - a.x * b.z;
            r.z = a.x * b.y - a.y * b.x;
            return r;
        endfunction

        static function longint dot(vec3_t a, vec3_t b);
            return a.x * b.x + a.y * b.y + a.z * b.z;
        endfunction

        static function int sign_of(longint v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        static function bit same_side(vec3_t p1, vec3_t p2, vec3_t p3, vec3_t opp, vec3_t q);
            vec3_t n;
            n = cross3(diff(p2, p1), diff(p3, p1));
            return sign_of(dot(n, diff(opp, p1))) == sign_of(dot(n, diff(q, p1)));
        endfunction

        function verdict_t classify_point(vec3_t q);
            vec3_t      v [pit_pkg::FACES];
            longint     det;
            bit [63:0]  mag;
            verdict_t   res;
            foreach (v[i]) v[i] = unpack_vertex(vertex[i]);
            res.in_tet = 1'b1;
            for (int f = 0; f < pit_pkg::FACES; f++) begin
                if (!same_side(v[f], v[(f + 1) % pit_pkg::FACES], v[(f + 2) % pit_pkg::FACES],
                               v[(f + 3) % pit_pkg::FACES], q))
                    res.in_tet = 1'b0;
            end
            det = dot(diff(v[0], v[3]), cross3(diff(v[1], v[3]), diff(v[2], v[3])));
            mag = (det < 0) ? 64'(-det) : 64'(det);
            res.six_vol = mag[pit_pkg::VOL_WIDTH-1:0];
            return res;
        endfunction

        function void note_query(logic [pit_pkg::IN_TDATA_WIDTH-1:0] tdata);
            vec3_t q;
            q.x = slot_value(tdata[15:0]);
            q.y = slot_value(tdata[31:16]);
            q.z = slot_value(tdata[47:32]);
            pending.push_back(classify_point(q));
        endfunction

        function void check_verdict(logic [pit_pkg::OUT_TDATA_WIDTH-1:0] tdata);
            verdict_t want;
            if (pending.size() == 0) begin
                flag($sformatf("result with nothing outstanding: tdata=%0h", tdata));
                return;
            end
            want = pending.pop_front();
            if (tdata[0] !== want.in_tet || tdata[pit_pkg::VOL_WIDTH:1] !== want.six_vol ||
                tdata[pit_pkg::OUT_TDATA_WIDTH-1:pit_pkg::VOL_WIDTH+1] !== '0)
                flag($sformatf("mismatch: expected inside=%0b six_volume=%0d, got inside=%0b %s",
                               want.in_tet, want.six_vol, tdata[0],
                               $sformatf("six_volume=%0d pad=%0h", tdata[pit_pkg::VOL_WIDTH:1],
                                         tdata[pit_pkg::OUT_TDATA_WIDTH-1:
                                               pit_pkg::VOL_WIDTH+1])));
        endfunction

        function bit all_clear();
            if (pending.size() != 0)
                flag($sformatf("%0d results never arrived", pending.size()));
            return faults == 0;
        endfunction
    endclass

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [pit_pkg::IN_TDATA_WIDTH-1:0]   s_tdata   = '0;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [pit_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [pit_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [pit_pkg::VERT_WIDTH-1:0]       cfg_data  = '0;

    tet_verdicts book;
    vec3_t       tet [pit_pkg::FACES];
    int          burst_left = 1;
    rx_mode_t    rx_mode    = RX_STEADY;
    int          rx_left    = 0;
    int          hold_left  = 0;

    point_in_tetrahedron_test_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) book.set_vertex(cfg_index, cfg_data);
            if (s_tvalid && s_tready) book.note_query(s_tdata);
            if (m_tvalid && m_tready) book.check_verdict(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_left <= $urandom_range(16, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        hold_left <= $urandom_range(2, 16);
                        m_tready  <= 1'b0;
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    function automatic vec3_t pt(longint x, longint y, longint z);
        vec3_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic longint rand_coord();
        return longint'($signed(16'($urandom)));
    endfunction

    function automatic longint near(longint centre, int unsigned span);
        return centre + longint'($urandom_range(0, 2 * span)) - longint'(span);
    endfunction

    function automatic logic [pit_pkg::VERT_WIDTH-1:0] pack_vertex(vec3_t v);
        return {v.x[15:0], v.y[15:0], v.z[15:0]};
    endfunction

    function automatic void pick_tetra(shape_t shape);
        vec3_t c;
        c = pt(near(0, 30000), near(0, 30000), near(0, 30000));
        foreach (tet[i]) begin
            case (shape)
                SHAPE_WIDE:    tet[i] = pt(rand_coord(), rand_coord(), rand_coord());
                SHAPE_CORNERS: tet[i] = pt($urandom_range(0, 1) ? 32767 : -32768,
                                           $urandom_range(0, 1) ? 32767 : -32768,
                                           $urandom_range(0, 1) ? 32767 : -32768);
                default:       tet[i] = pt(near(c.x, 300), near(c.y, 300), near(c.z, 300));
            endcase
        end
        if (shape == SHAPE_FLAT)
            tet[3] = pt(tet[0].x + tet[1].x - tet[2].x, tet[0].y + tet[1].y - tet[2].y,
                        tet[0].z + tet[1].z - tet[2].z);
    endfunction

    function automatic vec3_t pick_query();
        int unsigned kind;
        int          i;
        int          j;
        int          k;
        longint      w [pit_pkg::FACES];
        longint      wsum;
        vec3_t       q;
        kind = $urandom_range(0, 99);
        i    = $urandom_range(0, 3);
        j    = (i + 1 + $urandom_range(0, 2)) % pit_pkg::FACES;
        k    = (j + 1) % pit_pkg::FACES == i ? (j + 2) % pit_pkg::FACES
                                             : (j + 1) % pit_pkg::FACES;
        if (kind < 35) begin
            q = pt(rand_coord(), rand_coord(), rand_coord());
        end else if (kind < 60) begin
            wsum = 0;
            q    = pt(0, 0, 0);
            foreach (w[n]) begin
                w[n] = longint'($urandom_range(1, 100));
                wsum += w[n];
                q.x  += w[n] * tet[n].x;
                q.y  += w[n] * tet[n].y;
                q.z  += w[n] * tet[n].z;
            end
            q = pt(q.x / wsum, q.y / wsum, q.z / wsum);
        end else if (kind < 70) begin
            q = tet[i];
        end else if (kind < 80) begin
            if (kind < 75)
                q = pt((tet[i].x + tet[j].x) / 2, (tet[i].y + tet[j].y) / 2,
                       (tet[i].z + tet[j].z) / 2);
            else
                q = pt((tet[i].x + tet[j].x + tet[k].x) / 3,
                       (tet[i].y + tet[j].y + tet[k].y) / 3,
                       (tet[i].z + tet[j].z + tet[k].z) / 3);
        end else begin
            q = pt(near(tet[i].x, 3), near(tet[i].y, 3), near(tet[i].z, 3));
        end
        return q;
    endfunction

    task automatic push_query(input vec3_t q);
        s_tvalid <= 1'b1;
        s_tdata  <= {q.z[15:0], q.y[15:0], q.x[15:0]};
        do @(posedge aclk); while (!s_tready);
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 48);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (book.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [pit_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [pit_pkg::VERT_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_tetra(input bit stray);
        logic [pit_pkg::CFG_INDEX_WIDTH-1:0] reg_idx [pit_pkg::FACES];
        int                                  first;
        reg_idx = '{pit_pkg::REG_VERTEX_A, pit_pkg::REG_VERTEX_B,
                    pit_pkg::REG_VERTEX_C, pit_pkg::REG_VERTEX_D};
        first   = $urandom_range(0, 3);
        // out-of-range index: must leave every vertex untouched
        if (stray)
            write_reg(pit_pkg::CFG_INDEX_WIDTH'($urandom_range(32'(pit_pkg::REG_VERTEX_D) + 1,
                                                               255)),
                      {16'($urandom), 32'($urandom)});
        for (int n = 0; n < pit_pkg::FACES; n++)
            write_reg(reg_idx[(first + n) % pit_pkg::FACES],
                      pack_vertex(tet[(first + n) % pit_pkg::FACES]));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        book = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // all-zero vertices after reset: every point counts as inside
        push_query(pt(0, 0, 0));
        push_query(pt(32767, 32767, 32767));
        push_query(pt(-32768, -32768, -32768));
        wait_drained();

        tet = '{pt(0, 0, 0), pt(1000, 0, 0), pt(0, 1000, 0), pt(0, 0, 1000)};
        load_tetra(1'b1);
        push_query(pt(100, 100, 100));
        push_query(pt(0, 0, 0));
        push_query(pt(300, 300, 0));
        push_query(pt(500, 500, 0));
        push_query(pt(-1, 0, 0));
        push_query(pt(333, 333, 333));
        push_query(pt(334, 333, 333));
        push_query(pt(334, 334, 334));
        push_query(pt(2000, 2000, 2000));
        push_query(pt(32767, -32768, 32767));
        push_query(pt(-32768, 32767, -32768));
        wait_drained();

        // widest corners: right-angled corner tetrahedron over the full coordinate range
        tet = '{pt(-32768, -32768, -32768), pt(32767, -32768, -32768),
                pt(-32768, 32767, -32768), pt(-32768, -32768, 32767)};
        load_tetra(1'b0);
        push_query(pt(0, 0, 0));
        push_query(pt(-32768, -32768, -32768));
        push_query(pt(32767, 32767, 32767));
        push_query(pt(-32767, -32767, -32767));
        push_query(pt(32767, -32768, -32768));
        wait_drained();

        // flat tetrahedron: only points in its plane pass
        tet = '{pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(10, 10, 0)};
        load_tetra(1'b1);
        push_query(pt(5, 5, 0));
        push_query(pt(100, -7, 0));
        push_query(pt(5, 5, 1));
        wait_drained();

        for (int p = 0; p < 12; p++) begin
            pick_tetra(shape_t'(p % 4));
            load_tetra(bit'($urandom_range(0, 1)));
            repeat (119) push_query(pick_query());
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        if (book.all_clear())
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
